// ===== rtl/llqm_pkg.sv =====
// Shared types and constants of the linked list queue manager.
`timescale 1ns / 1ps

package llqm_pkg;

  localparam int OpW     = 1;
  localparam int QidW    = 2;
  localparam int NodeW   = 4;
  localparam int StatusW = 2;
  localparam int SizeW   = 5;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LINKED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOT_IN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_TAIL
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic prev_rd_en;
    logic node_we;
    logic queue_we;
    logic next_we;
    logic prev_we;
  } mem_cmd_t;

endpackage

// ===== rtl/llqm_if.sv =====
// Request and response channel interfaces of the linked list queue manager.
`timescale 1ns / 1ps

interface llqm_req_if import llqm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [QidW-1:0]  queue_id;
  logic [NodeW-1:0] node;

  modport source (output valid, output operation, output queue_id, output node, input ready);
  modport sink   (input valid, input operation, input queue_id, input node, output ready);
endinterface

interface llqm_rsp_if import llqm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SizeW-1:0]   size;
  logic [NodeW-1:0]   head_node;
  logic               queue_empty;

  modport source (output valid, output status, output size, output head_node,
                  output queue_empty, input ready);
  modport sink   (input valid, input status, input size, input head_node,
                  input queue_empty, output ready);
endinterface

// ===== rtl/llqm_mem.sv =====
// Node, queue and link memories with registered read data.
`timescale 1ns / 1ps

module llqm_mem import llqm_pkg::*; #(
  parameter int NODES  = 16,
  parameter int QUEUES = 4,
  localparam int NW    = $clog2(NODES),
  localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1,
  localparam int CW    = $clog2(NODES + 1)
) (
  input  logic                  clk_i,
  input  mem_cmd_t              cmd_i,
  input  logic [NW-1:0]         node_raddr_i,
  input  logic [QW-1:0]         queue_raddr_i,
  input  logic [NW-1:0]         prev_raddr_i,
  input  logic [NW-1:0]         node_waddr_i,
  input  logic                  mark_wr_i,
  input  logic [QW-1:0]         owner_wr_i,
  input  logic [QW-1:0]         queue_waddr_i,
  input  logic [NW-1:0]         head_wr_i,
  input  logic [CW-1:0]         count_wr_i,
  input  logic [NW-1:0]         next_waddr_i,
  input  logic [NW-1:0]         next_wr_i,
  input  logic [NW-1:0]         prev_waddr_i,
  input  logic [NW-1:0]         prev_wr_i,
  output logic                  mark_o,
  output logic [QW-1:0]         owner_o,
  output logic [NW-1:0]         head_o,
  output logic [CW-1:0]         count_o,
  output logic [NW-1:0]         next_o,
  output logic [NW-1:0]         prev_o
);

  logic [QW:0]        node_mem  [NODES];
  logic [NW+CW-1:0]   queue_mem [QUEUES];
  logic [NW-1:0]      next_mem  [NODES];
  logic [NW-1:0]      prev_mem  [NODES];

  logic [QW:0]        node_rd_q;
  logic [NW+CW-1:0]   queue_rd_q;
  logic [NW-1:0]      next_rd_q;
  logic [NW-1:0]      prev_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      node_rd_q <= node_mem[node_raddr_i];
    end
    if (cmd_i.node_we) begin
      node_mem[node_waddr_i] <= {mark_wr_i, owner_wr_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      queue_rd_q <= queue_mem[queue_raddr_i];
    end
    if (cmd_i.queue_we) begin
      queue_mem[queue_waddr_i] <= {head_wr_i, count_wr_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      next_rd_q <= next_mem[node_raddr_i];
    end
    if (cmd_i.next_we) begin
      next_mem[next_waddr_i] <= next_wr_i;
    end
  end

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.prev_rd_en) begin
      prev_rd_q <= prev_mem[prev_raddr_i];
    end
    if (cmd_i.prev_we) begin
      prev_mem[prev_waddr_i] <= prev_wr_i;
    end
  end

  assign mark_o  = node_rd_q[QW];
  assign owner_o = node_rd_q[QW-1:0];
  assign head_o  = queue_rd_q[NW+CW-1:CW];
  assign count_o = queue_rd_q[CW-1:0];
  assign next_o  = next_rd_q;
  assign prev_o  = prev_rd_q;

endmodule

// ===== rtl/llqm_ctrl.sv =====
// Sequencer: clearing pass after reset, handshake, memory read-modify-write and result register.
`timescale 1ns / 1ps

module llqm_ctrl import llqm_pkg::*; #(
  parameter int NODES  = 16,
  parameter int QUEUES = 4,
  localparam int NW    = $clog2(NODES),
  localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1,
  localparam int CW    = $clog2(NODES + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  llqm_req_if.sink        req_i,
  llqm_rsp_if.source      rsp_o,
  output mem_cmd_t        cmd_o,
  output logic [NW-1:0]   node_raddr_o,
  output logic [QW-1:0]   queue_raddr_o,
  output logic [NW-1:0]   prev_raddr_o,
  output logic [NW-1:0]   node_waddr_o,
  output logic            mark_wr_o,
  output logic [QW-1:0]   owner_wr_o,
  output logic [QW-1:0]   queue_waddr_o,
  output logic [NW-1:0]   head_wr_o,
  output logic [CW-1:0]   count_wr_o,
  output logic [NW-1:0]   next_waddr_o,
  output logic [NW-1:0]   next_wr_o,
  output logic [NW-1:0]   prev_waddr_o,
  output logic [NW-1:0]   prev_wr_o,
  input  logic            mark_i,
  input  logic [QW-1:0]   owner_i,
  input  logic [NW-1:0]   head_i,
  input  logic [CW-1:0]   count_i,
  input  logic [NW-1:0]   next_i,
  input  logic [NW-1:0]   prev_i
);

  localparam int MAXE = (NODES > QUEUES) ? NODES : QUEUES;
  localparam int SW   = $clog2(MAXE);
  localparam int NRW  = ((NW > NodeW) ? NW : NodeW) + 1;
  localparam int QRW  = ((QW > QidW) ? QW : QidW) + 1;

  function automatic logic [NW-1:0] node_mod(logic [NodeW-1:0] v);
    logic [NRW-1:0] r;
    r = NRW'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= NRW'(NODES)) r = r - NRW'(NODES);
    end
    return r[NW-1:0];
  endfunction

  function automatic logic [QW-1:0] queue_mod(logic [QidW-1:0] v);
    logic [QRW-1:0] r;
    r = QRW'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= QRW'(QUEUES)) r = r - QRW'(QUEUES);
    end
    return r[QW-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [SW-1:0]    clr_q, clr_d;
  op_e              op_q, op_d;
  logic [QW-1:0]    qid_q, qid_d;
  logic [NW-1:0]    node_q, node_d;
  logic [NW-1:0]    hd_q, hd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic             rsp_valid_q, rsp_valid_d;
  status_e          status_q, status_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [NodeW-1:0] head_q, head_d;
  logic             empty_q, empty_d;

  logic [NW-1:0]    node_in;
  logic [QW-1:0]    qid_in;
  logic             out_free;
  logic             load;
  status_e          res_status;
  logic [CW-1:0]    res_cnt;
  logic [NW-1:0]    res_head;
  logic             member;
  logic [NW-1:0]    new_head;

  assign node_in  = node_mod(req_i.node);
  assign qid_in   = queue_mod(req_i.queue_id);
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign member   = mark_i && (owner_i == qid_q);
  assign new_head = (head_i != node_q) ? head_i :
                    (count_i == CW'(1)) ? '0 : next_i;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    op_d          = op_q;
    qid_d         = qid_q;
    node_d        = node_q;
    hd_d          = hd_q;
    cnt_d         = cnt_q;
    req_i.ready   = 1'b0;
    cmd_o         = '0;
    node_raddr_o  = node_in;
    queue_raddr_o = qid_in;
    prev_raddr_o  = node_in;
    node_waddr_o  = node_q;
    mark_wr_o     = 1'b0;
    owner_wr_o    = qid_q;
    queue_waddr_o = qid_q;
    head_wr_o     = head_i;
    count_wr_o    = count_i;
    next_waddr_o  = node_q;
    next_wr_o     = node_q;
    prev_waddr_o  = node_q;
    prev_wr_o     = node_q;
    load          = 1'b0;
    res_status    = ST_OK;
    res_cnt       = count_i;
    res_head      = head_i;

    case (state_q)
      S_CLEAR: begin
        cmd_o.node_we  = ({1'b0, clr_q} < (SW+1)'(NODES));
        cmd_o.queue_we = ({1'b0, clr_q} < (SW+1)'(QUEUES));
        node_waddr_o   = clr_q[NW-1:0];
        owner_wr_o     = '0;
        queue_waddr_o  = clr_q[QW-1:0];
        head_wr_o      = '0;
        count_wr_o     = '0;
        clr_d          = clr_q + SW'(1);
        if (clr_q == SW'(MAXE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          cmd_o.rd_en      = 1'b1;
          cmd_o.prev_rd_en = 1'b1;
          op_d             = op_e'(req_i.operation);
          qid_d            = qid_in;
          node_d           = node_in;
          state_d          = S_LOOK;
        end
      end
      S_LOOK: begin
        if (op_q == OP_APPEND) begin
          if (mark_i) begin
            res_status = ST_LINKED;
            if (out_free) begin
              load    = 1'b1;
              state_d = S_IDLE;
            end
          end else if (count_i == '0) begin
            if (out_free) begin
              cmd_o.next_we  = 1'b1;
              cmd_o.prev_we  = 1'b1;
              cmd_o.node_we  = 1'b1;
              cmd_o.queue_we = 1'b1;
              mark_wr_o      = 1'b1;
              head_wr_o      = node_q;
              count_wr_o     = CW'(1);
              res_cnt        = CW'(1);
              res_head       = node_q;
              load           = 1'b1;
              state_d        = S_IDLE;
            end
          end else begin
            // link node before head, fetch the old tail from prev[head]
            cmd_o.next_we    = 1'b1;
            cmd_o.prev_we    = 1'b1;
            cmd_o.node_we    = 1'b1;
            cmd_o.queue_we   = 1'b1;
            cmd_o.prev_rd_en = 1'b1;
            prev_raddr_o     = head_i;
            next_wr_o        = head_i;
            prev_waddr_o     = head_i;
            mark_wr_o        = 1'b1;
            count_wr_o       = count_i + CW'(1);
            hd_d             = head_i;
            cnt_d            = count_i + CW'(1);
            state_d          = S_TAIL;
          end
        end else begin
          if (out_free) begin
            load    = 1'b1;
            state_d = S_IDLE;
            if (count_i == '0) begin
              res_status = ST_EMPTY;
            end else if (!member) begin
              res_status = ST_NOT_IN;
            end else begin
              cmd_o.next_we  = 1'b1;
              cmd_o.prev_we  = 1'b1;
              cmd_o.node_we  = 1'b1;
              cmd_o.queue_we = 1'b1;
              next_waddr_o   = prev_i;
              next_wr_o      = next_i;
              prev_waddr_o   = next_i;
              prev_wr_o      = prev_i;
              head_wr_o      = new_head;
              count_wr_o     = count_i - CW'(1);
              res_cnt        = count_i - CW'(1);
              res_head       = new_head;
            end
          end
        end
      end
      S_TAIL: begin
        res_cnt  = cnt_q;
        res_head = hd_q;
        if (out_free) begin
          cmd_o.next_we = 1'b1;
          cmd_o.prev_we = 1'b1;
          next_waddr_o  = prev_i;
          next_wr_o     = node_q;
          prev_waddr_o  = node_q;
          prev_wr_o     = prev_i;
          load          = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    status_d    = status_q;
    size_d      = size_q;
    head_d      = head_q;
    empty_d     = empty_q;
    if (load) begin
      rsp_valid_d = 1'b1;
      status_d    = res_status;
      size_d      = SizeW'(res_cnt);
      empty_d     = (res_cnt == '0);
      head_d      = (res_cnt == '0) ? '0 : NodeW'(res_head);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    qid_q    <= qid_d;
    node_q   <= node_d;
    hd_q     <= hd_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    size_q   <= size_d;
    head_q   <= head_d;
    empty_q  <= empty_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.size        = size_q;
  assign rsp_o.head_node   = head_q;
  assign rsp_o.queue_empty = empty_q;

endmodule

// ===== rtl/linked_list_queue_manager.sv =====
// Result register: loaded in the lookup state; for an append to a nonempty queue, in the tail state.
// Requests: one at a time, ready only when idle; each takes a memory read, then write-back, and an
//   append to a nonempty queue a tail step that links the old tail fetched from the prev link memory;
//   a response not yet taken holds the sequencer. Reset: asynchronous, active low; then a clearing
//   pass with ready low zeroes the linked marks and queue counts.
`timescale 1ns / 1ps

module linked_list_queue_manager import llqm_pkg::*; #(
  parameter int NODES  = 16,
  parameter int QUEUES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  llqm_req_if.sink    req_i,
  llqm_rsp_if.source  rsp_o
);

  localparam int NW = $clog2(NODES);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int CW = $clog2(NODES + 1);

  mem_cmd_t        cmd;
  logic [NW-1:0]   node_raddr;
  logic [QW-1:0]   queue_raddr;
  logic [NW-1:0]   prev_raddr;
  logic [NW-1:0]   node_waddr;
  logic            mark_wr;
  logic [QW-1:0]   owner_wr;
  logic [QW-1:0]   queue_waddr;
  logic [NW-1:0]   head_wr;
  logic [CW-1:0]   count_wr;
  logic [NW-1:0]   next_waddr;
  logic [NW-1:0]   next_wr;
  logic [NW-1:0]   prev_waddr;
  logic [NW-1:0]   prev_wr;
  logic            mark;
  logic [QW-1:0]   owner;
  logic [NW-1:0]   head;
  logic [CW-1:0]   count;
  logic [NW-1:0]   next_rd;
  logic [NW-1:0]   prev_rd;

  llqm_ctrl #(
    .NODES  (NODES),
    .QUEUES (QUEUES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .cmd_o         (cmd),
    .node_raddr_o  (node_raddr),
    .queue_raddr_o (queue_raddr),
    .prev_raddr_o  (prev_raddr),
    .node_waddr_o  (node_waddr),
    .mark_wr_o     (mark_wr),
    .owner_wr_o    (owner_wr),
    .queue_waddr_o (queue_waddr),
    .head_wr_o     (head_wr),
    .count_wr_o    (count_wr),
    .next_waddr_o  (next_waddr),
    .next_wr_o     (next_wr),
    .prev_waddr_o  (prev_waddr),
    .prev_wr_o     (prev_wr),
    .mark_i        (mark),
    .owner_i       (owner),
    .head_i        (head),
    .count_i       (count),
    .next_i        (next_rd),
    .prev_i        (prev_rd)
  );

  llqm_mem #(
    .NODES  (NODES),
    .QUEUES (QUEUES)
  ) u_mem (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .node_raddr_i  (node_raddr),
    .queue_raddr_i (queue_raddr),
    .prev_raddr_i  (prev_raddr),
    .node_waddr_i  (node_waddr),
    .mark_wr_i     (mark_wr),
    .owner_wr_i    (owner_wr),
    .queue_waddr_i (queue_waddr),
    .head_wr_i     (head_wr),
    .count_wr_i    (count_wr),
    .next_waddr_i  (next_waddr),
    .next_wr_i     (next_wr),
    .prev_waddr_i  (prev_waddr),
    .prev_wr_i     (prev_wr),
    .mark_o        (mark),
    .owner_o       (owner),
    .head_o        (head),
    .count_o       (count),
    .next_o        (next_rd),
    .prev_o        (prev_rd)
  );

endmodule
